@@ src/source_text_tokenizer_assert.svh @@
// Assertion helpers for the tokenizer; compiled out for synthesis.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer assertion failed");
`define STT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tokenizer forbidden condition seen");
`else
`define STT_ASSERT(lbl, clk, rst_n, prop)
`define STT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ src/stt_pkg.sv @@
`default_nettype none
package stt_pkg;
    localparam int KEYWORD_CHARS = 6;
    localparam int LINE_BITS     = 16;
    localparam int WLEN_W        = $clog2(KEYWORD_CHARS + 2);

    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_INT     = 3'd1;
    localparam logic [2:0] MODE_WORD    = 3'd2;
    localparam logic [2:0] MODE_STR     = 3'd3;
    localparam logic [2:0] MODE_OP      = 3'd4;
    localparam logic [2:0] MODE_COMMENT = 3'd5;
    localparam logic [2:0] MODE_ERR     = 3'd6;

    localparam logic [4:0] KIND_PIECE  = 5'd0;
    localparam logic [4:0] KIND_INT    = 5'd1;
    localparam logic [4:0] KIND_IDENT  = 5'd2;
    localparam logic [4:0] KIND_STRING = 5'd3;
    localparam logic [4:0] KIND_IF     = 5'd4;
    localparam logic [4:0] KIND_ELSE   = 5'd5;
    localparam logic [4:0] KIND_WHILE  = 5'd6;
    localparam logic [4:0] KIND_GOTO   = 5'd7;
    localparam logic [4:0] KIND_GOSUB  = 5'd8;
    localparam logic [4:0] KIND_RETURN = 5'd9;
    localparam logic [4:0] KIND_PRINT  = 5'd10;
    localparam logic [4:0] KIND_EQ     = 5'd11;
    localparam logic [4:0] KIND_NE     = 5'd12;
    localparam logic [4:0] KIND_GE     = 5'd13;
    localparam logic [4:0] KIND_LE     = 5'd14;
    localparam logic [4:0] KIND_PLUS   = 5'd15;
    localparam logic [4:0] KIND_MINUS  = 5'd16;
    localparam logic [4:0] KIND_STAR   = 5'd17;
    localparam logic [4:0] KIND_SLASH  = 5'd18;
    localparam logic [4:0] KIND_ASSIGN = 5'd19;
    localparam logic [4:0] KIND_GT     = 5'd20;
    localparam logic [4:0] KIND_LT     = 5'd21;
    localparam logic [4:0] KIND_LPAREN = 5'd22;
    localparam logic [4:0] KIND_RPAREN = 5'd23;
    localparam logic [4:0] KIND_LBRACE = 5'd24;
    localparam logic [4:0] KIND_RBRACE = 5'd25;
    localparam logic [4:0] KIND_COMMA  = 5'd26;
    localparam logic [4:0] KIND_SEMI   = 5'd27;
    localparam logic [4:0] KIND_END    = 5'd28;
    localparam logic [4:0] KIND_ERROR  = 5'd29;

    localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
    // (INT_MAX31 - d) / 10 for small and large digits
    localparam logic [30:0] SAT_LIMIT_LO = 31'(INT_MAX31 / 10);
    localparam logic [30:0] SAT_LIMIT_HI = 31'((INT_MAX31 - 8) / 10);

    typedef logic [7:0] prefix_t [KEYWORD_CHARS];

    typedef struct packed {
        logic [4:0]           token_kind;
        logic [7:0]           piece_char;
        logic [30:0]          int_value;
        logic [LINE_BITS-1:0] line_number;
        logic                 last_result;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } result_pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || c inside {[8'd9:8'd13]};
    endfunction

    // kind of a one-byte operator; error for a bare '!' or a non-operator
    function automatic logic [4:0] op1_kind(input logic [7:0] c);
        case (c)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "=":     return KIND_ASSIGN;
            ">":     return KIND_GT;
            "<":     return KIND_LT;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            ",":     return KIND_COMMA;
            ";":     return KIND_SEMI;
            default: return KIND_ERROR;
        endcase
    endfunction

    function automatic logic [4:0] op2_kind(input logic [7:0] c);
        case (c)
            "=":     return KIND_EQ;
            "!":     return KIND_NE;
            ">":     return KIND_GE;
            "<":     return KIND_LE;
            default: return KIND_ERROR;
        endcase
    endfunction

    function automatic logic op_first(input logic [7:0] c);
        return c == "!" || op1_kind(c) != KIND_ERROR;
    endfunction

    function automatic logic [4:0] word_kind(input prefix_t p, input logic [WLEN_W-1:0] len);
        logic [4:0] k;
        k = KIND_IDENT;
        if (len == WLEN_W'(2) && p[0] == "i" && p[1] == "f")
            k = KIND_IF;
        if (len == WLEN_W'(4) && p[0] == "e" && p[1] == "l" && p[2] == "s" && p[3] == "e")
            k = KIND_ELSE;
        if (len == WLEN_W'(5) && p[0] == "w" && p[1] == "h" && p[2] == "i" && p[3] == "l"
            && p[4] == "e")
            k = KIND_WHILE;
        if (len == WLEN_W'(4) && p[0] == "g" && p[1] == "o" && p[2] == "t" && p[3] == "o")
            k = KIND_GOTO;
        if (len == WLEN_W'(5) && p[0] == "g" && p[1] == "o" && p[2] == "s" && p[3] == "u"
            && p[4] == "b")
            k = KIND_GOSUB;
        if (len == WLEN_W'(6) && p[0] == "r" && p[1] == "e" && p[2] == "t" && p[3] == "u"
            && p[4] == "r" && p[5] == "n")
            k = KIND_RETURN;
        if (len == WLEN_W'(5) && p[0] == "p" && p[1] == "r" && p[2] == "i" && p[3] == "n"
            && p[4] == "t")
            k = KIND_PRINT;
        return k;
    endfunction
endpackage
`default_nettype wire

@@ src/stt_in_if.sv @@
`default_nettype none
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface
`default_nettype wire

@@ src/stt_out_if.sv @@
`default_nettype none
interface stt_out_if;
    logic                          valid;
    logic                          ready;
    logic [4:0]                    token_kind;
    logic [7:0]                    piece_char;
    logic [30:0]                   int_value;
    logic [stt_pkg::LINE_BITS-1:0] line_number;
    logic                          last_result;

    modport source (output valid, output token_kind, output piece_char, output int_value,
                    output line_number, output last_result, input ready);
    modport sink   (input valid, input token_kind, input piece_char, input int_value,
                    input line_number, input last_result, output ready);
endinterface
`default_nettype wire

@@ src/stt_scanner.sv @@
`default_nettype none
module stt_scanner (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           char_code,
    input  wire logic                 end_of_input,
    output stt_pkg::result_pair_t     results
);
    logic [2:0]                    mode_reg, mode_next;
    logic [30:0]                   acc_reg, acc_next;
    logic [stt_pkg::LINE_BITS-1:0] line_reg, line_next;
    stt_pkg::prefix_t              wp_reg, wp_next;
    logic [stt_pkg::WLEN_W-1:0]    wl_reg, wl_next;
    logic [7:0]                    oc0_reg, oc0_next;
    logic [1:0]                    ol_reg, ol_next;

    logic       fl_has, fl_err;
    logic [4:0] fl_kind;
    logic [30:0] fl_val;

    localparam logic [stt_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [stt_pkg::LINE_BITS-1:0] LINE_ONE = stt_pkg::LINE_BITS'(1);

    // pending token that the current byte would close
    always_comb
    begin
        fl_has  = 1'b0;
        fl_err  = 1'b0;
        fl_kind = stt_pkg::KIND_ERROR;
        fl_val  = '0;
        case (mode_reg)
            stt_pkg::MODE_INT:
            begin
                fl_has  = 1'b1;
                fl_kind = stt_pkg::KIND_INT;
                fl_val  = acc_reg;
            end
            stt_pkg::MODE_WORD:
            begin
                fl_has  = 1'b1;
                fl_kind = (wl_reg > stt_pkg::WLEN_W'(stt_pkg::KEYWORD_CHARS))
                        ? stt_pkg::KIND_IDENT : stt_pkg::word_kind(wp_reg, wl_reg);
            end
            stt_pkg::MODE_OP:
            begin
                fl_has  = 1'b1;
                fl_kind = (ol_reg == 2'd2) ? stt_pkg::op2_kind(oc0_reg)
                                           : stt_pkg::op1_kind(oc0_reg);
                fl_err  = fl_kind == stt_pkg::KIND_ERROR;
            end
            default:
            begin
                fl_has = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stt_pkg::result_t r [2];
        logic       n;
        logic       cnt;
        logic       do_start;
        logic [4:0] k;
        logic [7:0] pc;
        logic [30:0] v;
        logic       put;
        logic       put2;
        logic [3:0] d;
        logic       nl;

        mode_next = mode_reg;
        acc_next  = acc_reg;
        line_next = line_reg;
        wp_next   = wp_reg;
        wl_next   = wl_reg;
        oc0_next  = oc0_reg;
        ol_next   = ol_reg;
        r[0]      = '0;
        r[1]      = '0;
        n         = 1'b0;
        cnt       = 1'b0;
        do_start  = 1'b0;
        put       = 1'b0;
        put2      = 1'b0;
        k         = stt_pkg::KIND_ERROR;
        pc        = '0;
        v         = '0;
        d         = char_code[3:0] - 4'd0 ;
        nl        = char_code == 8'd10;

        if (end_of_input)
        begin
            if (mode_reg == stt_pkg::MODE_ERR || mode_reg == stt_pkg::MODE_STR
                || mode_reg > stt_pkg::MODE_ERR)
            begin
                mode_next = stt_pkg::MODE_ERR;
                put = 1'b1;
                k   = stt_pkg::KIND_ERROR;
            end
            else
            begin
                if (fl_has)
                begin
                    r[0].token_kind  = fl_kind;
                    r[0].int_value   = fl_val;
                    r[0].line_number = line_reg;
                    n = 1'b1;
                end
                if (fl_err)
                    mode_next = stt_pkg::MODE_ERR;
                else
                begin
                    put2      = 1'b1;
                    k         = stt_pkg::KIND_END;
                    mode_next = stt_pkg::MODE_INIT;
                    line_next = LINE_ONE;
                end
            end
        end
        else
        begin
            case (mode_reg)
                stt_pkg::MODE_INIT:
                    do_start = 1'b1;
                stt_pkg::MODE_INT:
                begin
                    if (stt_pkg::is_digit(char_code))
                    begin
                        if (acc_reg > ((d >= 4'd8) ? stt_pkg::SAT_LIMIT_HI
                                                   : stt_pkg::SAT_LIMIT_LO))
                            acc_next = stt_pkg::INT_MAX31;
                        else
                            acc_next = {acc_reg[27:0], 3'b000} + {acc_reg[29:0], 1'b0}
                                     + {27'd0, d};
                    end
                    else
                        do_start = 1'b1;
                end
                stt_pkg::MODE_WORD:
                begin
                    if (stt_pkg::is_alpha(char_code) || stt_pkg::is_digit(char_code)
                        || char_code == "_")
                    begin
                        if (wl_reg < stt_pkg::WLEN_W'(stt_pkg::KEYWORD_CHARS))
                            wp_next[wl_reg] = char_code;
                        if (wl_reg <= stt_pkg::WLEN_W'(stt_pkg::KEYWORD_CHARS))
                            wl_next = wl_reg + 1'b1;
                        put = 1'b1;
                        k   = stt_pkg::KIND_PIECE;
                        pc  = char_code;
                    end
                    else
                        do_start = 1'b1;
                end
                stt_pkg::MODE_STR:
                begin
                    put = 1'b1;
                    if (char_code == "\"")
                    begin
                        mode_next = stt_pkg::MODE_INIT;
                        k = stt_pkg::KIND_STRING;
                    end
                    else
                    begin
                        cnt = nl;
                        k   = stt_pkg::KIND_PIECE;
                        pc  = char_code;
                    end
                end
                stt_pkg::MODE_OP:
                begin
                    if (ol_reg == 2'd1 && char_code == "="
                        && stt_pkg::op2_kind(oc0_reg) != stt_pkg::KIND_ERROR)
                        ol_next = 2'd2;
                    else
                        do_start = 1'b1;
                end
                stt_pkg::MODE_COMMENT:
                begin
                    if (nl)
                    begin
                        cnt       = 1'b1;
                        mode_next = stt_pkg::MODE_INIT;
                    end
                end
                default:
                begin
                    mode_next = stt_pkg::MODE_ERR;
                    put = 1'b1;
                    k   = stt_pkg::KIND_ERROR;
                end
            endcase

            if (do_start)
            begin
                if (fl_has)
                begin
                    r[0].token_kind  = fl_kind;
                    r[0].int_value   = fl_val;
                    r[0].line_number = line_reg;
                    n = 1'b1;
                end
                if (fl_err)
                    mode_next = stt_pkg::MODE_ERR;
                else
                begin
                    mode_next = stt_pkg::MODE_INIT;
                    if (stt_pkg::is_digit(char_code))
                    begin
                        acc_next  = {27'd0, d};
                        mode_next = stt_pkg::MODE_INT;
                    end
                    else if (stt_pkg::is_alpha(char_code) || char_code == "_")
                    begin
                        wp_next[0] = char_code;
                        wl_next    = stt_pkg::WLEN_W'(1);
                        mode_next  = stt_pkg::MODE_WORD;
                        put2 = 1'b1;
                        k    = stt_pkg::KIND_PIECE;
                        pc   = char_code;
                    end
                    else if (char_code == "\"")
                        mode_next = stt_pkg::MODE_STR;
                    else if (stt_pkg::op_first(char_code))
                    begin
                        oc0_next  = char_code;
                        ol_next   = 2'd1;
                        mode_next = stt_pkg::MODE_OP;
                    end
                    else if (stt_pkg::is_space(char_code))
                        cnt = nl;
                    else if (char_code == "#")
                        mode_next = stt_pkg::MODE_COMMENT;
                    else
                    begin
                        mode_next = stt_pkg::MODE_ERR;
                        put2 = 1'b1;
                        k    = stt_pkg::KIND_ERROR;
                    end
                end
            end
        end

        if (cnt && line_reg != LINE_MAX)
            line_next = line_reg + 1'b1;

        // the second slot is used only after a flushed token
        if (put || put2)
        begin
            r[n].token_kind  = k;
            r[n].piece_char  = pc;
            r[n].int_value   = v;
            // a string newline is counted before its own piece goes out
            r[n].line_number = (mode_reg == stt_pkg::MODE_STR && !end_of_input)
                             ? line_next : line_reg;
        end

        results.push0 = accept && (n || put || put2);
        results.push1 = accept && n && (put || put2);
        r[0].last_result = !(n && (put || put2));
        r[1].last_result = 1'b1;
        results.res0 = r[0];
        results.res1 = r[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= stt_pkg::MODE_INIT;
            acc_reg  <= '0;
            line_reg <= LINE_ONE;
            wl_reg   <= '0;
            ol_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            line_reg <= line_next;
            wl_reg   <= wl_next;
            ol_reg   <= ol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wp_reg  <= wp_next;
            oc0_reg <= oc0_next;
        end
    end
endmodule
`default_nettype wire

@@ src/stt_result_queue.sv @@
`default_nettype none
`include "source_text_tokenizer_assert.svh"
module stt_result_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire stt_pkg::result_pair_t push,
    output logic                      room_for_two,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output stt_pkg::result_t          head
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    stt_pkg::result_t q_reg [DEPTH];
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [AW:0]      count_reg, count_next;
    logic             pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = count_reg != '0;
    assign head         = q_reg[head_reg];
    assign room_for_two = count_reg <= (AW+1)'(DEPTH - 2);

    always_comb
    begin
        head_next  = head_reg + AW'(pop);
        tail_next  = tail_reg + AW'(push.push0) + AW'(push.push1);
        count_next = count_reg + (AW+1)'(push.push0) + (AW+1)'(push.push1)
                   - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
            q_reg[tail_reg] <= push.res0;
        if (push.push1)
            q_reg[tail_reg + 1'b1] <= push.res1;
    end

    `STT_NEVER(a_no_overflow, clk, rst_n, count_reg > (AW+1)'(DEPTH))
    `STT_ASSERT(a_second_needs_first, clk, rst_n, push.push1 |-> push.push0)
    `STT_ASSERT(a_push_has_room, clk, rst_n, push.push0 |-> room_for_two)
endmodule
`default_nettype wire

@@ src/source_text_tokenizer.sv @@
`default_nettype none
// Streaming lexer: one source byte (or end-of-input marker) per request, one request
// per cycle. Each byte is decoded combinationally against fixed keyword and operator
// tables and yields zero, one or two token results, which go into a four-entry result
// queue; input is taken while that queue has room for two results, so the sustained
// rate is one byte per cycle as long as bytes average at most one result and the sink
// keeps up. Identifier and string bytes come out as piece results, followed by the
// closing token; errors are sticky until reset.
module source_text_tokenizer (
    input wire logic   clk,
    input wire logic   rst_n,
    stt_in_if.sink     bytes,
    stt_out_if.source  tokens
);
    stt_pkg::result_pair_t pair;
    stt_pkg::result_t      head;
    logic                  room;
    logic                  accept;

    assign bytes.ready = room;
    assign accept      = bytes.valid && room;

    stt_scanner u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (bytes.char_code),
        .end_of_input (bytes.end_of_input),
        .results      (pair)
    );

    stt_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (pair),
        .room_for_two (room),
        .out_valid    (tokens.valid),
        .out_ready    (tokens.ready),
        .head         (head)
    );

    assign tokens.token_kind  = head.token_kind;
    assign tokens.piece_char  = head.piece_char;
    assign tokens.int_value   = head.int_value;
    assign tokens.line_number = head.line_number;
    assign tokens.last_result = head.last_result;
endmodule
`default_nettype wire
